// ===== sv/tsmrs_pkg.sv =====
// Shared types, register indexes and constants for the three-stage motor run sequencer.
package tsmrs_pkg;

  localparam int TIME_W   = 16;
  localparam int PERIOD_W = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Duty is floor(126 * period / 255), done as a multiply by a rounded-up
  // reciprocal; exact for every 20-bit period.
  localparam int DUTY_MAGIC_W = 31;
  localparam logic [DUTY_MAGIC_W-1:0] DUTY_MAGIC = 31'd2122219135;
  localparam int DUTY_SHIFT = 32;
  localparam int DUTY_PROD_W = PERIOD_W + DUTY_MAGIC_W;

  localparam logic [15:0] JAM_CODE = 16'hEEEE;

  localparam logic REQ_MOVE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [1:0] STAGE_FIRST  = 2'd0;
  localparam logic [1:0] STAGE_SECOND = 2'd1;
  localparam logic [1:0] STAGE_THIRD  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLARITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LIM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LIM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THIRD_PER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_JAM_TIME  = 3'd6;

  typedef struct packed {
    logic        req_type;
    logic        move_dir;
    logic [15:0] run_time_ms;
  } in_item_t;

  typedef struct packed {
    logic                running;
    logic                dir_level;
    logic [1:0]          stage;
    logic [PERIOD_W-1:0] step_period;
    logic [PERIOD_W-1:0] duty_ns;
    logic                finished;
  } out_item_t;

  typedef struct packed {
    logic                polarity_negative;
    logic [15:0]         first_limit_ms;
    logic [15:0]         second_limit_ms;
    logic [PERIOD_W-1:0] first_period_ns;
    logic [PERIOD_W-1:0] second_period_ns;
    logic [PERIOD_W-1:0] third_period_ns;
    logic [15:0]         jam_time_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        stage_index;
    logic [TIME_W-1:0] total_left;
    logic [TIME_W-1:0] stage_run;
    logic [TIME_W-1:0] stage_left;
    logic              held_dir;
    logic              active;
  } move_state_t;

endpackage

// ===== sv/tsmrs_cfg.sv =====
// Configuration register file for the motor run sequencer.
module tsmrs_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tsmrs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsmrs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output tsmrs_pkg::cfg_t                     cfg
);
  import tsmrs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_POLARITY:   cfg_nxt.polarity_negative = cfg_wdata[0];
        CFG_FIRST_LIM:  cfg_nxt.first_limit_ms    = cfg_wdata[15:0];
        CFG_SECOND_LIM: cfg_nxt.second_limit_ms   = cfg_wdata[15:0];
        CFG_FIRST_PER:  cfg_nxt.first_period_ns   = cfg_wdata[PERIOD_W-1:0];
        CFG_SECOND_PER: cfg_nxt.second_period_ns  = cfg_wdata[PERIOD_W-1:0];
        CFG_THIRD_PER:  cfg_nxt.third_period_ns   = cfg_wdata[PERIOD_W-1:0];
        CFG_JAM_TIME:   cfg_nxt.jam_time_ms       = cfg_wdata[15:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.polarity_negative <= 1'b0;
      cfg_r.first_limit_ms    <= 16'd70;
      cfg_r.second_limit_ms   <= 16'd391;
      cfg_r.first_period_ns   <= 20'd40000;
      cfg_r.second_period_ns  <= 20'd26666;
      cfg_r.third_period_ns   <= 20'd80000;
      cfg_r.jam_time_ms       <= 16'd1500;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/tsmrs_step.sv =====
// Next move state and result item for one command or millisecond tick.
module tsmrs_step (
  input  tsmrs_pkg::in_item_t    item,
  input  tsmrs_pkg::move_state_t st,
  input  tsmrs_pkg::cfg_t        cfg,
  output tsmrs_pkg::move_state_t st_nxt,
  output tsmrs_pkg::out_item_t   result
);
  import tsmrs_pkg::*;

  logic              start;
  logic              halt;
  logic [1:0]        start_stage;
  logic [TIME_W-1:0] start_total;
  logic [TIME_W-1:0] left_dec;
  logic [TIME_W-1:0] run;
  logic [PERIOD_W-1:0]    period;
  logic [DUTY_PROD_W-1:0] duty_prod;

  always_comb begin
    st_nxt      = st;
    start       = 1'b0;
    halt        = 1'b0;
    start_stage = STAGE_FIRST;
    start_total = '0;
    left_dec    = (st.stage_left != '0) ? st.stage_left - 1'b1 : '0;
    run         = '0;

    if (item.req_type == REQ_MOVE) begin
      // A new command drops whatever move is in progress.
      st_nxt.held_dir = item.move_dir;
      start = 1'b1;
      if (item.run_time_ms == JAM_CODE) begin
        start_stage = STAGE_THIRD;
        start_total = TIME_W'(cfg.jam_time_ms);
      end else begin
        start_stage = STAGE_FIRST;
        start_total = TIME_W'(item.run_time_ms);
      end
    end else if (st.active) begin
      st_nxt.stage_left = left_dec;
      if (left_dec == '0) begin
        if (st.stage_index == STAGE_THIRD) begin
          halt = 1'b1;
        end else begin
          start       = 1'b1;
          start_stage = st.stage_index + 2'd1;
          start_total = st.total_left - st.stage_run;
        end
      end
    end

    if (start && start_total == '0) begin
      halt = 1'b1;
    end

    if (halt) begin
      st_nxt.stage_index = STAGE_FIRST;
      st_nxt.total_left  = '0;
      st_nxt.stage_run   = '0;
      st_nxt.stage_left  = '0;
      st_nxt.active      = 1'b0;
    end else if (start) begin
      case (start_stage)
        STAGE_FIRST:  run = (start_total > TIME_W'(cfg.first_limit_ms)) ?
                            TIME_W'(cfg.first_limit_ms) : start_total;
        STAGE_SECOND: run = (start_total > TIME_W'(cfg.second_limit_ms)) ?
                            TIME_W'(cfg.second_limit_ms) : start_total;
        default:      run = start_total;
      endcase
      st_nxt.stage_index = start_stage;
      st_nxt.total_left  = start_total;
      st_nxt.stage_run   = run;
      st_nxt.stage_left  = run;
      st_nxt.active      = 1'b1;
    end
  end

  always_comb begin
    case (st_nxt.stage_index)
      STAGE_FIRST:  period = cfg.first_period_ns;
      STAGE_SECOND: period = cfg.second_period_ns;
      default:      period = cfg.third_period_ns;
    endcase
  end

  assign duty_prod = DUTY_PROD_W'(period) * DUTY_PROD_W'(DUTY_MAGIC);

  always_comb begin
    result          = '0;
    result.finished = halt;
    if (st_nxt.active) begin
      result.running     = 1'b1;
      result.dir_level   = cfg.polarity_negative ? st_nxt.held_dir : ~st_nxt.held_dir;
      result.stage       = st_nxt.stage_index;
      result.step_period = period;
      result.duty_ns     = PERIOD_W'(duty_prod[DUTY_PROD_W-1:DUTY_SHIFT]);
    end
  end

endmodule

// ===== sv/three_stage_motor_run_sequencer_core.sv =====
// Three-stage motor run sequencer: top level with input and result registers.
//
// Items arrive on the in_ channel: a move command (direction and total time
// in ms, 0xEEEE for jammed, 0 to stop) or a one-millisecond tick. Every
// item yields exactly one result on the out_ channel: running, direction
// pin level, stage, step period, pulse duty and a finished flag.
// A transfer happens at a rising edge with valid high and stall low.
// An accepted item is held in the input register; the move state and the
// result register update together when it advances, which shows its result.
// One item per cycle is sustained while the receiver does not stall; the
// state update plus the duty multiply is the one logic step. When the
// receiver stalls, the result register holds and the input register still
// takes one more item; after that in_stall rises until the result moves on.
// Synchronous active-low reset empties both registers, stops the motor and
// loads the register defaults. The cfg_ port is to be written only while
// idle; the block itself does not enforce it.
module three_stage_motor_run_sequencer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tsmrs_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tsmrs_pkg::out_item_t              out_data,
  input  logic                              cfg_we,
  input  logic [tsmrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsmrs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import tsmrs_pkg::*;

  cfg_t        cfg;
  logic        in_vld_r;
  in_item_t    in_item_r;
  move_state_t st_r;
  move_state_t st_nxt;
  out_item_t   result;
  logic        out_vld_r;
  out_item_t   out_item_r;
  logic        advance;
  logic        in_take;

  tsmrs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tsmrs_step u_step (
    .item   (in_item_r),
    .st     (st_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .result (result)
  );

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  a_finished_stops : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.finished && out_data.running))
    else $error("finished result still shows the motor running");

  a_stopped_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.running) |->
      (out_data.step_period == '0 && out_data.duty_ns == '0))
    else $error("stopped result carries a period or duty");

  a_left_in_run : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.active |-> (st_r.stage_left <= st_r.stage_run && st_r.stage_run <= st_r.total_left))
    else $error("stage countdown outside its stage time");

  a_idle_clear : assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.active |-> (st_r.total_left == '0 && st_r.stage_left == '0))
    else $error("stopped motor keeps time left");

  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r && out_stall))
    else $error("input stalled with room to advance");

endmodule
